// ===== hw/rtl/pfba_pkg.sv =====
// package for the page frame bitmap allocator
// action and status codes, field widths, structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfba_pkg;

    localparam int MAP_PAGES = 512;

    localparam int ACT_W     = 2;
    localparam int PAGE_W    = 9;
    localparam int STS_W     = 2;
    localparam int CNT_W     = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INIT  = 2'd2;

    localparam logic [STS_W-1:0] STS_OK     = 2'd0;
    localparam logic [STS_W-1:0] STS_NOFREE = 2'd1;
    localparam logic [STS_W-1:0] STS_BAD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 1'd1;

    localparam logic [CFG_W-1:0] FIRST_FREE_RST = 10'd0;
    localparam logic [CFG_W-1:0] PAGE_LIMIT_RST = 10'd512;

    typedef struct packed {
        logic load;
        logic look_alloc;
        logic look_free;
        logic exec_alloc;
        logic exec_free;
        logic init_start;
        logic init_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/pfba_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pfba_ctrl.sv =====
// controller state machine for the page frame bitmap allocator
// depends on pfba_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfba_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [pfba_pkg::ACT_W-1:0]   i_action,
    output logic                              o_stall,
    output pfba_pkg::t_cmd                    o_cmd,
    input  wire pfba_pkg::t_sts               i_sts
);

    import pfba_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_INIT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_is_free, n_is_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_free <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_free <= n_is_free;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_is_free = r_is_free;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_action)
                        ACT_ALLOC: begin
                            n_is_free = 1'b0;
                            n_state   = S_LOOK;
                        end
                        ACT_FREE: begin
                            n_is_free = 1'b1;
                            n_state   = S_LOOK;
                        end
                        ACT_INIT: begin
                            o_cmd.init_start = 1'b1;
                            n_state          = S_INIT;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                o_cmd.look_alloc = !r_is_free;
                o_cmd.look_free  = r_is_free;
                n_state          = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec_alloc = !r_is_free;
                o_cmd.exec_free  = r_is_free;
                n_state          = S_DONE;
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pfba_dp.sv =====
// datapath: free bitmap ram, per-word nonzero summary, free count,
// config registers and result register; depends on pfba_pkg and pfba_ram
`timescale 1ns / 1ps
`default_nettype none

module pfba_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pfba_pkg::t_cmd                  i_cmd,
    output pfba_pkg::t_sts                       o_sts,
    input  wire logic [pfba_pkg::PAGE_W-1:0]     i_page,
    input  wire logic                            i_cfg_we,
    input  wire logic [pfba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pfba_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic      [pfba_pkg::PAGE_W-1:0]     o_granted_page,
    output logic      [pfba_pkg::STS_W-1:0]      o_status,
    output logic      [pfba_pkg::CNT_W-1:0]      o_free_count
);

    import pfba_pkg::*;

    localparam int WORDS = (MAP_PAGES + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = (AW + 6 > CFG_W) ? AW + 6 : CFG_W;

    logic [CFG_W-1:0]  r_first, r_limit;
    logic [WORDS-1:0]  r_summary;
    logic [CNT_W-1:0]  r_count;
    logic [AW-1:0]     r_sweep;
    logic [AW-1:0]     r_word;
    logic              r_hit;
    logic [PAGE_W-1:0] r_page;
    logic [PAGE_W-1:0] r_res_granted;
    logic [STS_W-1:0]  r_res_status;
    logic              r_out_valid;
    logic [PAGE_W-1:0] r_out_granted;
    logic [STS_W-1:0]  r_out_status;
    logic [CNT_W-1:0]  r_out_count;

    logic [PW-1:0]     lim_ext, first_ext, page_ext, base_ext, grant_ext;
    logic [AW-1:0]     alloc_word, free_word, raddr, waddr;
    logic              in_range;
    logic [WORD_W-1:0] rdata, cur_word, alloc_word_new, free_word_new, init_mask, wdata;
    logic [BIT_W-1:0]  low_bit;
    logic              we;
    logic [CNT_W-1:0]  init_count;

    // clamped limit and range checks
    always_comb begin
        lim_ext   = (PW'(r_limit) > PW'(MAP_PAGES)) ? PW'(MAP_PAGES) : PW'(r_limit);
        first_ext = PW'(r_first);
        page_ext  = PW'(r_page);
        in_range  = page_ext < lim_ext;
        free_word = in_range ? page_ext[BIT_W +: AW] : '0;
        init_count = (lim_ext > first_ext) ? CNT_W'(lim_ext - first_ext) : '0;
    end

    // lowest nonzero word
    always_comb begin
        alloc_word = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (r_summary[i]) begin
                alloc_word = AW'(i);
            end
        end
    end

    assign raddr = i_cmd.look_alloc ? alloc_word : free_word;

    // a word whose summary bit is clear holds no free page
    assign cur_word = r_summary[r_word] ? rdata : '0;

    always_comb begin
        low_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (cur_word[i]) begin
                low_bit = BIT_W'(i);
            end
        end
        alloc_word_new = cur_word & ~(WORD_W'(1) << low_bit);
        free_word_new  = cur_word | (WORD_W'(1) << r_page[BIT_W-1:0]);
        grant_ext      = PW'({r_word, low_bit});
    end

    // init mask for the word under the sweep
    always_comb begin
        base_ext = PW'({r_sweep, {BIT_W{1'b0}}});
        for (int b = 0; b < WORD_W; b++) begin
            init_mask[b] = ((base_ext + PW'(b)) >= first_ext) &&
                           ((base_ext + PW'(b)) < lim_ext);
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_word;
        wdata = alloc_word_new;
        if (i_cmd.init_step) begin
            we    = 1'b1;
            waddr = r_sweep;
            wdata = init_mask;
        end else if (i_cmd.exec_alloc) begin
            we = r_hit;
        end else if (i_cmd.exec_free) begin
            we    = r_hit && !cur_word[r_page[BIT_W-1:0]];
            wdata = free_word_new;
        end
    end

    pfba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= FIRST_FREE_RST;
            r_limit     <= PAGE_LIMIT_RST;
            r_summary   <= '0;
            r_count     <= '0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FIRST_FREE: r_first <= i_cfg_data;
                    REG_PAGE_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.init_start) begin
                r_summary <= '0;
                r_count   <= init_count;
                r_sweep   <= '0;
            end
            if (i_cmd.init_step) begin
                r_summary[r_sweep] <= |init_mask;
                r_sweep            <= r_sweep + AW'(1);
            end
            if (i_cmd.exec_alloc && r_hit) begin
                r_summary[r_word] <= |alloc_word_new;
                r_count           <= r_count - CNT_W'(1);
            end
            if (i_cmd.exec_free && r_hit && !cur_word[r_page[BIT_W-1:0]]) begin
                r_summary[r_word] <= 1'b1;
                r_count           <= r_count + CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page        <= i_page;
            r_res_granted <= '0;
            r_res_status  <= STS_OK;
        end
        if (i_cmd.look_alloc || i_cmd.look_free) begin
            r_word <= raddr;
            r_hit  <= i_cmd.look_alloc ? (|r_summary) : in_range;
        end
        if (i_cmd.exec_alloc) begin
            if (r_hit) begin
                r_res_granted <= grant_ext[PAGE_W-1:0];
            end else begin
                r_res_status <= STS_NOFREE;
            end
        end
        if (i_cmd.exec_free && (!r_hit || cur_word[r_page[BIT_W-1:0]])) begin
            r_res_status <= STS_BAD;
        end
        if (i_cmd.out_load) begin
            r_out_granted <= r_res_granted;
            r_out_status  <= r_res_status;
            r_out_count   <= r_count;
        end
    end

    assign o_sts.sweep_last = (r_sweep == AW'(WORDS - 1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_granted_page = r_out_granted;
    assign o_status       = r_out_status;
    assign o_free_count   = r_out_count;

endmodule

`default_nettype wire

// ===== hw/rtl/page_frame_bitmap_allocator_unit.sv =====
// top level of the page frame bitmap allocator
// depends on pfba_pkg, pfba_ctrl, pfba_dp, pfba_ram
//
//   channel   handshake               payload
//   request   i_valid / o_stall       i_action, i_page
//   result    o_valid / i_stall       o_granted_page, o_status, o_free_count
//   config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// allocate and free run as accept, summary search and map read,
// map update, result load
// reinitialize sweeps every map word, one map word written per cycle
// an unused action code goes straight to result load
// after reset the map is empty and no clearing pass runs
// a stalled result holds the block in its last step; the next request
// is taken while the previous result waits
`timescale 1ns / 1ps
`default_nettype none

module page_frame_bitmap_allocator_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [pfba_pkg::ACT_W-1:0]      i_action,
    input  wire logic [pfba_pkg::PAGE_W-1:0]     i_page,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [pfba_pkg::PAGE_W-1:0]     o_granted_page,
    output logic      [pfba_pkg::STS_W-1:0]      o_status,
    output logic      [pfba_pkg::CNT_W-1:0]      o_free_count,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pfba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pfba_pkg::CFG_W-1:0]      i_cfg_data
);

    import pfba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    pfba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    pfba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_page         (i_page),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_granted_page (o_granted_page),
        .o_status       (o_status),
        .o_free_count   (o_free_count)
    );

endmodule

`default_nettype wire
